// ===== rtl/core/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, constants and the double-dabble step for the signed
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  // input word width and decimal digit count of a 32-bit magnitude
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);

  // conversion pipeline shape: binary bits consumed per stage
  localparam int unsigned DD_BITS    = 8;
  localparam int unsigned DD_STAGES  = VALUE_W / DD_BITS;

  // character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // word travelling down the conversion pipeline
  typedef struct packed {
    logic               neg;
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } sitda_work_t;

  typedef logic [NUM_DIGITS-1:0][3:0] sitda_digits_t;

  // one double-dabble step: add three to every digit of five or more,
  // then shift left taking in the next binary bit
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bit_in);
    logic [BCD_W-1:0] adj;
    logic [3:0]       d;
    adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[4*i +: 4];
      if (d >= 4'd5) begin
        adj[4*i +: 4] = d + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

endpackage

// ===== rtl/core/sitda_front.sv =====
// ----------------------------------------------------------------------------
// sitda_front
// Input stage: registers the word, takes the sign and forms the magnitude.
// ----------------------------------------------------------------------------
module sitda_front
  import sitda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output sitda_work_t        out_work
);

  logic        valid_r, valid_nxt;
  sitda_work_t work_r, work_nxt;
  logic        load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  // sign and magnitude; the most negative value wraps to 2^31 unsigned
  always_comb begin
    work_nxt     = work_r;
    valid_nxt    = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    if (load) begin
      work_nxt.neg = in_value[VALUE_W-1];
      work_nxt.bcd = '0;
      work_nxt.bin = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule

// ===== rtl/core/sitda_dd_stage.sv =====
// ----------------------------------------------------------------------------
// sitda_dd_stage
// One conversion stage: DD_BITS double-dabble steps, then a register.
// ----------------------------------------------------------------------------
module sitda_dd_stage
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sitda_work_t in_work,
  output logic        out_valid,
  input  logic        out_ready,
  output sitda_work_t out_work
);

  logic        valid_r, valid_nxt;
  sitda_work_t work_r, work_nxt;
  sitda_work_t step_w;

  assign in_ready = !valid_r || out_ready;

  // shift DD_BITS binary bits into the decimal digits
  always_comb begin
    step_w = in_work;
    for (int s = 0; s < DD_BITS; s++) begin
      step_w.bcd = dd_step(step_w.bcd, step_w.bin[VALUE_W-1]);
      step_w.bin = {step_w.bin[VALUE_W-2:0], 1'b0};
    end
  end

  // advance when the next stage has room
  always_comb begin
    valid_nxt = valid_r;
    work_nxt  = work_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        work_nxt = step_w;
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule

// ===== rtl/core/sitda_ser.sv =====
// ----------------------------------------------------------------------------
// sitda_ser
// Character serialiser: finds the leading digit, then sends the sign and
// the digits one word a cycle while out_ready holds, flagging the last one.
// ----------------------------------------------------------------------------
module sitda_ser
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sitda_work_t in_work,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_code,
  output logic        out_last_char
);

  logic             busy_r, busy_nxt;
  logic             neg_pend_r, neg_pend_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  sitda_digits_t    digits_r, digits_nxt;
  sitda_digits_t    in_digits;
  logic [IDX_W-1:0] lead_idx;
  logic [3:0]       cur_digit;
  logic             load;
  logic             take;

  assign in_digits = sitda_digits_t'(in_work.bcd);

  // highest nonzero digit; zero gives the units digit alone
  always_comb begin
    lead_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (in_digits[i] != 4'd0) begin
        lead_idx = IDX_W'(i);
      end
    end
  end

  // output word straight from the registers
  assign cur_digit     = digits_r[idx_r];
  assign out_valid     = busy_r;
  assign out_char_code = neg_pend_r ? CHAR_MINUS : (CHAR_ZERO + {4'd0, cur_digit});
  assign out_last_char = !neg_pend_r && (idx_r == '0);

  assign take     = busy_r && out_ready;
  assign in_ready = !busy_r || (out_ready && out_last_char);
  assign load     = in_valid && in_ready;

  // sequencing through sign and digits
  always_comb begin
    busy_nxt     = busy_r;
    neg_pend_nxt = neg_pend_r;
    idx_nxt      = idx_r;
    digits_nxt   = digits_r;
    if (take) begin
      if (neg_pend_r) begin
        neg_pend_nxt = 1'b0;
      end else if (idx_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - IDX_W'(1);
      end
    end
    if (load) begin
      busy_nxt     = 1'b1;
      neg_pend_nxt = in_work.neg;
      idx_nxt      = lead_idx;
      digits_nxt   = in_digits;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    neg_pend_r <= neg_pend_nxt;
    idx_r      <= idx_nxt;
    digits_r   <= digits_nxt;
  end

`ifndef SYNTH
  // digit index stays inside the digit row
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= IDX_W'(NUM_DIGITS - 1)))
    else $error("digit index out of range");

  // conversion leaves only decimal digits
  a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !neg_pend_r) |-> (cur_digit <= 4'd9))
    else $error("non-decimal digit");

  // a negative word opens with the minus sign
  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_work.neg) |=> (out_valid && out_char_code == CHAR_MINUS))
    else $error("minus sign missing");

  // for a non-negative word the first digit sent is never a leading zero unless it is the only one
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !in_work.neg && lead_idx != '0) |=> (cur_digit != 4'd0))
    else $error("leading zero sent");
`endif

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal text, one ASCII
// character per output word, most significant first, last one flagged.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_ready, in_value[31:0]      | in
//   output  | out_valid, out_ready, out_char_code[7:0],| out
//           | out_last_char                           |
//
// From input word to first character a number passes the sign and
// negation stage, four double-dabble stages of eight bits, and the loading
// of the serialiser.
// Each number holds the serialiser until all of its characters (1 to 11)
// are taken; that single character port sets the sustained rate.
// Reset clears every valid bit; payload registers are not reset.
// A stall on the output backs up through the stages without loss.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char_code,
  output logic               out_last_char
);

  logic        stg_valid [DD_STAGES+1];
  logic        stg_ready [DD_STAGES+1];
  sitda_work_t stg_work  [DD_STAGES+1];

  // sign and magnitude
  sitda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_work  (stg_work[0])
  );

  // binary to decimal digits
  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
    sitda_dd_stage u_dd (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_work   (stg_work[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_work  (stg_work[g+1])
    );
  end

  // character sequencing
  sitda_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (stg_valid[DD_STAGES]),
    .in_ready      (stg_ready[DD_STAGES]),
    .in_work       (stg_work[DD_STAGES]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule
